// File: rtl/ecg_beat_rate_classifier_assert.svh
// ---------------------------------------------------------------------------
// ecg beat rate classifier assertion macros
// shared property forms for the checker
// ---------------------------------------------------------------------------
`ifndef ECG_BEAT_RATE_CLASSIFIER_ASSERT_SVH
`define ECG_BEAT_RATE_CLASSIFIER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define ECGBRC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ecgbrc assertion failed");

// consequent must hold in the cycle after the antecedent
`define ECGBRC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ecgbrc assertion failed");

`endif

// File: rtl/ecgbrc_pkg.sv
// ---------------------------------------------------------------------------
// ecg beat rate classifier package
// shared constants, register map, state and interface types
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ecgbrc_pkg;

   localparam int FRAME_LEN    = 500;
   localparam int POS_W        = 12;
   localparam int SAMPLE_W     = 12;
   localparam int BLANK_W      = 10;
   localparam int LIMIT_W      = 8;
   localparam int NUM_W        = 24;
   localparam int RATE_W       = 16;
   localparam int CLASS_W      = 2;
   localparam int DIV_STEPS    = NUM_W;
   localparam int DIV_CNT_W    = $clog2(DIV_STEPS);
   localparam int CSR_ADDR_W   = 5;
   localparam int CSR_DATA_W   = 32;

   localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 12'd350;
   localparam logic [BLANK_W-1:0]  BLANKING_RESET  = 10'd70;
   localparam logic [LIMIT_W-1:0]  TACHY_RESET     = 8'd91;
   localparam logic [LIMIT_W-1:0]  BRADY_RESET     = 8'd59;
   localparam logic [NUM_W-1:0]    NUMERATOR_RESET = 24'd1200000;

   typedef enum logic [2:0] {
      REG_BEAT_THRESHOLD,
      REG_BLANKING_SAMPLES,
      REG_TACHY_LIMIT_BPM,
      REG_BRADY_LIMIT_BPM,
      REG_RATE_NUMERATOR
   } ecgbrc_reg_type;

   typedef enum logic [CLASS_W-1:0] {
      CLASS_NORMAL,
      CLASS_TACHY,
      CLASS_BRADY,
      CLASS_ON_LIMIT
   } ecgbrc_class_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_EMIT
   } ecgbrc_state_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] beat_threshold;
      logic [BLANK_W-1:0]  blanking_samples;
      logic [LIMIT_W-1:0]  tachy_limit_bpm;
      logic [LIMIT_W-1:0]  brady_limit_bpm;
      logic [NUM_W-1:0]    rate_numerator;
   } ecgbrc_cfg_type;

   typedef struct packed {
      logic take;
      logic div_start;
      logic div_step;
      logic emit;
   } ecgbrc_cmd_type;

   typedef struct packed {
      logic beat;
      logic first;
      logic div_last;
      logic out_free;
   } ecgbrc_stat_type;

endpackage

`default_nettype wire

// File: rtl/ecgbrc_ctrl.sv
// ---------------------------------------------------------------------------
// ecg beat rate classifier controller
// sequences sample intake, rate division and result hand-off
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ecgbrc_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire ecgbrc_pkg::ecgbrc_stat_type stat,
   output ecgbrc_pkg::ecgbrc_cmd_type    cmd
);
   import ecgbrc_pkg::*;

   ecgbrc_state_type state_ff;
   ecgbrc_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && stat.beat) begin
               state_in = stat.first ? ST_EMIT : ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (stat.div_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready     = 1'b0;
      cmd           = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.take      = req_valid;
            cmd.div_start = req_valid && stat.beat && !stat.first;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
         end
         ST_EMIT: begin
            cmd.emit = stat.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: rtl/ecgbrc_dp.sv
// ---------------------------------------------------------------------------
// ecg beat rate classifier datapath
// frame tracking, blanking, bit-serial rate divider, classifier, output reg
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ecgbrc_dp (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire ecgbrc_pkg::ecgbrc_cmd_type             cmd,
   output ecgbrc_pkg::ecgbrc_stat_type                 stat,
   input  wire ecgbrc_pkg::ecgbrc_cfg_type             cfg,
   input  wire logic [ecgbrc_pkg::SAMPLE_W-1:0]        req_sample,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic [ecgbrc_pkg::RATE_W-1:0]               rsp_rate_centi_bpm,
   output logic [ecgbrc_pkg::CLASS_W-1:0]              rsp_rhythm_class,
   output logic                                        rsp_first_in_frame
);
   import ecgbrc_pkg::*;

   // frame and beat state
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [POS_W-1:0]   last_beat_ff, last_beat_in;
   logic               seen_ff, seen_in;
   logic [BLANK_W-1:0] blank_ff, blank_in;
   logic [RATE_W-1:0]  rate_ff, rate_in;
   logic               first_pend_ff, first_pend_in;

   // divider
   logic [NUM_W-1:0]     quot_ff, quot_in;
   logic [POS_W-1:0]     rem_ff, rem_in;
   logic [POS_W-1:0]     divisor_ff, divisor_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;

   // output register
   logic                 out_valid_ff, out_valid_in;
   logic [RATE_W-1:0]    out_rate_ff, out_rate_in;
   logic [CLASS_W-1:0]   out_class_ff, out_class_in;
   logic                 out_first_ff, out_first_in;

   logic                 blank_active;
   logic                 beat;
   logic [POS_W:0]       pos_inc;
   logic                 wrap;
   logic [POS_W+1:0]     diff;
   logic [POS_W:0]       partial;
   logic                 fits;
   logic [RATE_W-1:0]    lim_hi;
   logic [RATE_W-1:0]    lim_lo;
   ecgbrc_class_type     cls;

   assign blank_active = (blank_ff != '0);
   assign beat         = !blank_active && (req_sample > cfg.beat_threshold);
   assign pos_inc      = {1'b0, pos_ff} + {{POS_W{1'b0}}, 1'b1};
   assign wrap         = (pos_inc >= (POS_W+1)'(FRAME_LEN));

   // one restoring step: shift in the next dividend bit, try the subtract
   assign partial = {rem_ff, quot_ff[NUM_W-1]};
   assign diff    = {1'b0, partial} - {2'b00, divisor_ff};
   assign fits    = !diff[POS_W+1];

   assign stat.beat     = beat;
   assign stat.first    = !seen_ff;
   assign stat.div_last = (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1));
   assign stat.out_free = !out_valid_ff || rsp_ready;

   assign lim_hi = {{(RATE_W-LIMIT_W){1'b0}}, cfg.tachy_limit_bpm} * RATE_W'(100);
   assign lim_lo = {{(RATE_W-LIMIT_W){1'b0}}, cfg.brady_limit_bpm} * RATE_W'(100);

   always_comb begin
      if (rate_ff > lim_hi) begin
         cls = CLASS_TACHY;
      end else if (rate_ff < lim_lo) begin
         cls = CLASS_BRADY;
      end else if ((lim_lo < rate_ff) && (rate_ff < lim_hi)) begin
         cls = CLASS_NORMAL;
      end else begin
         cls = CLASS_ON_LIMIT;
      end
   end

   always_comb begin
      pos_in        = pos_ff;
      last_beat_in  = last_beat_ff;
      seen_in       = seen_ff;
      blank_in      = blank_ff;
      first_pend_in = first_pend_ff;
      if (cmd.take) begin
         if (blank_active) begin
            blank_in = blank_ff - BLANK_W'(1);
         end else if (beat) begin
            last_beat_in  = pos_ff;
            seen_in       = 1'b1;
            blank_in      = cfg.blanking_samples;
            first_pend_in = !seen_ff;
         end
         if (wrap) begin
            pos_in   = '0;
            seen_in  = 1'b0;
            blank_in = '0;
         end else begin
            pos_in = pos_inc[POS_W-1:0];
         end
      end
   end

   always_comb begin
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      cnt_in     = cnt_ff;
      rate_in    = rate_ff;
      if (cmd.div_start) begin
         quot_in    = cfg.rate_numerator;
         rem_in     = '0;
         divisor_in = pos_ff - last_beat_ff;
         cnt_in     = '0;
      end else if (cmd.div_step) begin
         quot_in = {quot_ff[NUM_W-2:0], fits};
         rem_in  = fits ? diff[POS_W-1:0] : partial[POS_W-1:0];
         cnt_in  = cnt_ff + DIV_CNT_W'(1);
         if (stat.div_last) begin
            // a zero interval gives an all-ones quotient and saturates
            rate_in = (quot_in[NUM_W-1:RATE_W] != '0) ? '1 : quot_in[RATE_W-1:0];
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_rate_in  = out_rate_ff;
      out_class_in = out_class_ff;
      out_first_in = out_first_ff;
      if (cmd.emit) begin
         out_valid_in = 1'b1;
         out_rate_in  = rate_ff;
         out_class_in = cls;
         out_first_in = first_pend_ff;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         last_beat_ff <= '0;
         seen_ff      <= 1'b0;
         blank_ff     <= '0;
         rate_ff      <= '0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         last_beat_ff <= last_beat_in;
         seen_ff      <= seen_in;
         blank_ff     <= blank_in;
         rate_ff      <= rate_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      first_pend_ff <= first_pend_in;
      quot_ff       <= quot_in;
      rem_ff        <= rem_in;
      divisor_ff    <= divisor_in;
      out_rate_ff   <= out_rate_in;
      out_class_ff  <= out_class_in;
      out_first_ff  <= out_first_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_rate_centi_bpm = out_rate_ff;
   assign rsp_rhythm_class   = out_class_ff;
   assign rsp_first_in_frame = out_first_ff;

endmodule

`default_nettype wire

// File: rtl/ecg_beat_rate_classifier.sv
// ---------------------------------------------------------------------------
// ecg beat rate classifier
// Takes one 12-bit ECG sample per req item (valid/ready) and returns one
// rsp item per detected beat: rate in hundredths of bpm, rhythm class and a
// first-in-frame flag. Samples that are no beat give no result.
// A sample that is no beat leaves the block idle, ready again in the next
// cycle. The first beat of a frame goes straight to the emit state, then
// into the output register once it is free. Any other beat first runs a
// 24-step bit-serial divider, one quotient bit per cycle. No new sample is
// taken until the block is idle again. Settings must be written over the
// csr port only while no beat is in flight; the block does not enforce it.
// Reset clears frame position, blanking, beat history and rate to zero and
// loads the default settings; no result is pending after reset.
// A stalled rsp side holds its item; further samples are still taken, and a
// new beat waits after its division until the output register is free.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ecg_beat_rate_classifier (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic [ecgbrc_pkg::SAMPLE_W-1:0]        req_sample,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic [ecgbrc_pkg::RATE_W-1:0]               rsp_rate_centi_bpm,
   output logic [ecgbrc_pkg::CLASS_W-1:0]              rsp_rhythm_class,
   output logic                                        rsp_first_in_frame,
   input  wire logic                                   csr_psel,
   input  wire logic                                   csr_penable,
   input  wire logic                                   csr_pwrite,
   input  wire logic [ecgbrc_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire logic [ecgbrc_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [ecgbrc_pkg::CSR_DATA_W-1:0]           csr_prdata,
   output logic                                        csr_pready
);
   import ecgbrc_pkg::*;

   ecgbrc_cfg_type  cfg_ff, cfg_in;
   ecgbrc_cmd_type  cmd;
   ecgbrc_stat_type stat;
   logic [2:0]      reg_idx;
   logic            csr_wr;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (reg_idx)
            REG_BEAT_THRESHOLD:   cfg_in.beat_threshold   = csr_pwdata[SAMPLE_W-1:0];
            REG_BLANKING_SAMPLES: cfg_in.blanking_samples = csr_pwdata[BLANK_W-1:0];
            REG_TACHY_LIMIT_BPM:  cfg_in.tachy_limit_bpm  = csr_pwdata[LIMIT_W-1:0];
            REG_BRADY_LIMIT_BPM:  cfg_in.brady_limit_bpm  = csr_pwdata[LIMIT_W-1:0];
            REG_RATE_NUMERATOR:   cfg_in.rate_numerator   = csr_pwdata[NUM_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_BEAT_THRESHOLD:
            csr_prdata = {{(CSR_DATA_W-SAMPLE_W){1'b0}}, cfg_ff.beat_threshold};
         REG_BLANKING_SAMPLES:
            csr_prdata = {{(CSR_DATA_W-BLANK_W){1'b0}}, cfg_ff.blanking_samples};
         REG_TACHY_LIMIT_BPM:
            csr_prdata = {{(CSR_DATA_W-LIMIT_W){1'b0}}, cfg_ff.tachy_limit_bpm};
         REG_BRADY_LIMIT_BPM:
            csr_prdata = {{(CSR_DATA_W-LIMIT_W){1'b0}}, cfg_ff.brady_limit_bpm};
         REG_RATE_NUMERATOR:
            csr_prdata = {{(CSR_DATA_W-NUM_W){1'b0}}, cfg_ff.rate_numerator};
         default:
            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.beat_threshold   <= THRESHOLD_RESET;
         cfg_ff.blanking_samples <= BLANKING_RESET;
         cfg_ff.tachy_limit_bpm  <= TACHY_RESET;
         cfg_ff.brady_limit_bpm  <= BRADY_RESET;
         cfg_ff.rate_numerator   <= NUMERATOR_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ecgbrc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ecgbrc_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .cfg                (cfg_ff),
      .req_sample         (req_sample),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_rate_centi_bpm (rsp_rate_centi_bpm),
      .rsp_rhythm_class   (rsp_rhythm_class),
      .rsp_first_in_frame (rsp_first_in_frame)
   );

endmodule

`default_nettype wire

// File: rtl/ecgbrc_checker.sv
// ---------------------------------------------------------------------------
// ecg beat rate classifier checker
// port-level properties of the result channel, bound to the top level
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "ecg_beat_rate_classifier_assert.svh"

module ecgbrc_checker (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   rsp_valid,
   input  wire logic                                   rsp_ready,
   input  wire logic [ecgbrc_pkg::RATE_W-1:0]          rsp_rate_centi_bpm,
   input  wire logic [ecgbrc_pkg::CLASS_W-1:0]         rsp_rhythm_class,
   input  wire logic                                   rsp_first_in_frame
);
   import ecgbrc_pkg::*;

   // a stalled item stays offered
   `ECGBRC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // and keeps its payload
   `ECGBRC_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_rate_centi_bpm) && $stable(rsp_rhythm_class) && $stable(rsp_first_in_frame))

   // a saturated rate is above any tachy limit
   `ECGBRC_ASSERT_SAME(a_sat_tachy, clock, reset, rsp_valid && (rsp_rate_centi_bpm == '1), rsp_rhythm_class == CLASS_TACHY)

   // a zero rate can only be slow or sit on a zero limit
   `ECGBRC_ASSERT_SAME(a_zero_slow, clock, reset, rsp_valid && (rsp_rate_centi_bpm == '0), (rsp_rhythm_class == CLASS_BRADY) || (rsp_rhythm_class == CLASS_ON_LIMIT))

endmodule

bind ecg_beat_rate_classifier ecgbrc_checker u_checker (.*);

`default_nettype wire

// File: tb/sv/ecg_beat_rate_classifier_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ecg beat rate classifier testbench
// Streams ECG samples into the block and checks every beat report against
// a cycle-free software copy of the detector: frame position, blanking,
// beat interval division with saturation and rhythm classification.
// Settings are changed over the csr port between bursts, with read-back.
// Both handshakes idle at random; one long receiver hold fills the block.
// ---------------------------------------------------------------------------

module ecg_beat_rate_classifier_tb;

   import ecgbrc_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES  = 32;
   localparam int DRAIN_CYCLES   = 40;
   localparam int PRESSURE_HOLD  = 400;
   localparam int MAX_REPORTS    = 10;

   localparam logic [SAMPLE_W-1:0] OPENING_SAMPLES [19] = '{
      12'd0, 12'd350, 12'd351, 12'd4095, 12'd4095,
      12'd0, 12'd100, 12'd200, 12'd300, 12'd349, 12'd350, 12'd0,
      12'd4095, 12'd4095, 12'd0, 12'd4095, 12'd4095, 12'd4095, 12'd1
   };

   typedef struct {
      logic [RATE_W-1:0] rate;
      ecgbrc_class_type  rhythm;
      logic              first;
   } beat_report_type;

   // software copy of the detector plus the queue of beats still to come
   class beat_ledger;
      ecgbrc_cfg_type    cfg;
      logic [POS_W-1:0]   position;
      logic [POS_W-1:0]   last_beat;
      logic               beat_seen;
      logic [BLANK_W-1:0] blank_left;
      logic [RATE_W-1:0]  rate;
      beat_report_type    awaited_beats[$];
      int unsigned        mismatches;
      int unsigned        beats_matched;
      int unsigned        samples_taken;

      function new();
         cfg.beat_threshold   = THRESHOLD_RESET;
         cfg.blanking_samples = BLANKING_RESET;
         cfg.tachy_limit_bpm  = TACHY_RESET;
         cfg.brady_limit_bpm  = BRADY_RESET;
         cfg.rate_numerator   = NUMERATOR_RESET;
         position      = '0;
         last_beat     = '0;
         beat_seen     = 1'b0;
         blank_left    = '0;
         rate          = '0;
         mismatches    = 0;
         beats_matched = 0;
         samples_taken = 0;
      endfunction

      function void complain(string msg);
         mismatches++;
         if (mismatches <= MAX_REPORTS) $display("mismatch: %s", msg);
      endfunction

      function void write_reg(ecgbrc_reg_type idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            REG_BEAT_THRESHOLD:   cfg.beat_threshold   = value[SAMPLE_W-1:0];
            REG_BLANKING_SAMPLES: cfg.blanking_samples = value[BLANK_W-1:0];
            REG_TACHY_LIMIT_BPM:  cfg.tachy_limit_bpm  = value[LIMIT_W-1:0];
            REG_BRADY_LIMIT_BPM:  cfg.brady_limit_bpm  = value[LIMIT_W-1:0];
            REG_RATE_NUMERATOR:   cfg.rate_numerator   = value[NUM_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [CSR_DATA_W-1:0] reg_value(ecgbrc_reg_type idx);
         case (idx)
            REG_BEAT_THRESHOLD:   return CSR_DATA_W'(cfg.beat_threshold);
            REG_BLANKING_SAMPLES: return CSR_DATA_W'(cfg.blanking_samples);
            REG_TACHY_LIMIT_BPM:  return CSR_DATA_W'(cfg.tachy_limit_bpm);
            REG_BRADY_LIMIT_BPM:  return CSR_DATA_W'(cfg.brady_limit_bpm);
            REG_RATE_NUMERATOR:   return CSR_DATA_W'(cfg.rate_numerator);
            default:              return '0;
         endcase
      endfunction

      // tachy wins over brady when the limits cross
      function ecgbrc_class_type rhythm_of(logic [RATE_W-1:0] r);
         int unsigned hi;
         int unsigned lo;
         int unsigned rv;
         hi = int'(cfg.tachy_limit_bpm) * 100;
         lo = int'(cfg.brady_limit_bpm) * 100;
         rv = 32'(r);
         if (rv > hi) return CLASS_TACHY;
         if (rv < lo) return CLASS_BRADY;
         if (lo < rv && rv < hi) return CLASS_NORMAL;
         return CLASS_ON_LIMIT;
      endfunction

      function void take_sample(logic [SAMPLE_W-1:0] s);
         beat_report_type   beat;
         logic [POS_W-1:0]  interval;
         int unsigned       quotient;
         logic [POS_W-1:0]  next_pos;
         samples_taken++;
         if (blank_left != 0) begin
            blank_left = blank_left - BLANK_W'(1);
         end else if (s > cfg.beat_threshold) begin
            beat.first = !beat_seen;
            if (beat_seen) begin
               interval = position - last_beat;
               if (interval == 0) quotient = 65535;
               else quotient = int'(cfg.rate_numerator) / int'(interval);
               rate = (quotient > 65535) ? 16'hFFFF : quotient[RATE_W-1:0];
            end
            last_beat  = position;
            beat_seen  = 1'b1;
            blank_left = cfg.blanking_samples;
            beat.rate   = rate;
            beat.rhythm = rhythm_of(rate);
            awaited_beats.push_back(beat);
         end
         // frame wrap clears beat history and blanking
         next_pos = position + POS_W'(1);
         if (int'(position) + 1 >= FRAME_LEN || next_pos == 0) begin
            position   = '0;
            beat_seen  = 1'b0;
            blank_left = '0;
         end else begin
            position = next_pos;
         end
      endfunction

      function void match_beat(logic [RATE_W-1:0] r, logic [CLASS_W-1:0] c, logic f);
         beat_report_type want;
         if (awaited_beats.size() == 0) begin
            complain($sformatf("unexpected beat rate %0d class %0d first %0b", r, c, f));
            return;
         end
         want = awaited_beats.pop_front();
         beats_matched++;
         if (r !== want.rate || c !== want.rhythm || f !== want.first)
            complain($sformatf("beat %0d expected rate %0d class %0d first %0b, got %0d %0d %0b",
                               beats_matched, want.rate, want.rhythm, want.first, r, c, f));
      endfunction

      function int pending();
         return awaited_beats.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [SAMPLE_W-1:0]   req_sample = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [RATE_W-1:0]     rsp_rate_centi_bpm;
   logic [CLASS_W-1:0]    rsp_rhythm_class;
   logic                  rsp_first_in_frame;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   beat_ledger  ledger;
   bit          no_idle = 1'b0;
   int unsigned hold_request = 0;
   int unsigned settings_used = 0;
   int unsigned quiet_cycles = 0;

   ecg_beat_rate_classifier dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_sample         (req_sample),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_rate_centi_bpm (rsp_rate_centi_bpm),
      .rsp_rhythm_class   (rsp_rhythm_class),
      .rsp_first_in_frame (rsp_first_in_frame),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mostly short gaps, now and then a long one
   function int unsigned pick_gap();
      int unsigned r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // quiet baseline with peaks over the threshold, plus some raw noise
   function logic [SAMPLE_W-1:0] pick_sample(int unsigned peak_pct);
      int unsigned r;
      int unsigned thr;
      thr = 32'(ledger.cfg.beat_threshold);
      r = $urandom_range(0, 99);
      if (r < 8) return SAMPLE_W'($urandom_range(0, 4095));
      if (r < 8 + peak_pct && thr < 4095) return SAMPLE_W'($urandom_range(thr + 1, 4095));
      return SAMPLE_W'($urandom_range(0, thr));
   endfunction

   task automatic send_sample(input logic [SAMPLE_W-1:0] value, input bit last_one);
      int unsigned gap;
      req_valid  <= 1'b1;
      req_sample <= value;
      do @(posedge clock); while (!req_ready);
      ledger.take_sample(value);
      gap = pick_gap();
      if (gap > 0 || last_one) req_valid <= 1'b0;
      repeat (gap) @(posedge clock);
   endtask

   task automatic csr_write(input ecgbrc_reg_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      ledger.write_reg(idx, value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_check(input ecgbrc_reg_type idx);
      logic [CSR_DATA_W-1:0] got;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      if (got !== ledger.reg_value(idx))
         ledger.complain($sformatf("register %s read %0h, expected %0h",
                                   idx.name(), got, ledger.reg_value(idx)));
   endtask

   // waits out the last beat before touching any register
   task automatic apply_settings(input logic [CSR_DATA_W-1:0] thr, input logic [CSR_DATA_W-1:0] blank,
                                 input logic [CSR_DATA_W-1:0] tachy,
                                 input logic [CSR_DATA_W-1:0] brady,
                                 input logic [CSR_DATA_W-1:0] num);
      while (ledger.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write(REG_BEAT_THRESHOLD, thr);
      csr_write(REG_BLANKING_SAMPLES, blank);
      csr_write(REG_TACHY_LIMIT_BPM, tachy);
      csr_write(REG_BRADY_LIMIT_BPM, brady);
      csr_write(REG_RATE_NUMERATOR, num);
      for (int k = 0; k <= int'(REG_RATE_NUMERATOR); k++) csr_check(ecgbrc_reg_type'(k));
      settings_used++;
   endtask

   task automatic send_burst(input int unsigned count, input int unsigned peak_pct);
      for (int unsigned i = 0; i < count; i++)
         send_sample(pick_sample(peak_pct), i == count - 1);
   endtask

   initial begin : rsp_side
      int unsigned stall_left;
      int unsigned r;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            ledger.match_beat(rsp_rate_centi_bpm, rsp_rhythm_class, rsp_first_in_frame);
         if (hold_request != 0) begin
            stall_left   = hold_request;
            hold_request = 0;
         end else if (stall_left == 0 && !no_idle) begin
            r = $urandom_range(0, 99);
            if (r < 15) stall_left = $urandom_range(1, 3);
            else if (r < 18) stall_left = $urandom_range(10, 40);
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("ecg_beat_rate_classifier_tb failed");
            $finish;
         end
      end
   end

   initial begin : stimulus
      ledger = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int k = 0; k <= int'(REG_RATE_NUMERATOR); k++) csr_check(ecgbrc_reg_type'(k));

      // threshold edge, first beat, blanking, exact tachy limit, short interval
      apply_settings(CSR_DATA_W'(THRESHOLD_RESET), 2, CSR_DATA_W'(TACHY_RESET),
                     CSR_DATA_W'(BRADY_RESET), 91000);
      foreach (OPENING_SAMPLES[i])
         send_sample(OPENING_SAMPLES[i], i == $size(OPENING_SAMPLES) - 1);
      // zero threshold, zero blanking, zero numerator, crossed limits
      apply_settings(0, 0, 10, 200, 0);
      send_sample(12'd1, 1'b0);
      send_sample(12'd1, 1'b0);
      send_sample(12'd0, 1'b1);
      apply_settings(0, 0, 10, 200, 20000);
      send_sample(12'd4095, 1'b1);
      // saturation at the largest numerator
      apply_settings(0, 0, 10, 200, 32'hFFFFFF);
      send_sample(12'd4095, 1'b1);

      apply_settings(CSR_DATA_W'(THRESHOLD_RESET), CSR_DATA_W'(BLANKING_RESET),
                     CSR_DATA_W'(TACHY_RESET), CSR_DATA_W'(BRADY_RESET),
                     CSR_DATA_W'(NUMERATOR_RESET));
      send_burst(200, 12);

      // long receiver hold while samples keep coming back to back
      apply_settings(1500, 8, 120, 50, CSR_DATA_W'(NUMERATOR_RESET));
      no_idle = 1'b1;
      hold_request = PRESSURE_HOLD;
      send_burst(200, 25);
      no_idle = 1'b0;

      apply_settings(0, 1, 255, 0, $urandom_range(1, 32'hFFFFFF));
      send_burst(100, 0);
      apply_settings(4095, 1023, 0, 255, 1);
      send_burst(50, 30);
      // numerators that land right on a limit
      apply_settings(2048, 4, CSR_DATA_W'(TACHY_RESET), CSR_DATA_W'(BRADY_RESET), 35400);
      send_burst(150, 40);
      apply_settings(2048, 3, CSR_DATA_W'(TACHY_RESET), CSR_DATA_W'(BRADY_RESET), 45500);
      send_burst(150, 40);
      apply_settings(500, 1023, 200, 30, 32'hFFFFFF);
      send_burst(150, 30);
      repeat (4) begin
         apply_settings($urandom, $urandom, $urandom, $urandom, $urandom);
         send_burst(60, $urandom_range(5, 50));
      end

      while (ledger.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("ran %0d samples under %0d register settings, %0d beats compared",
               ledger.samples_taken, settings_used, ledger.beats_matched);
      $display("mismatches %0d, beats still awaited %0d", ledger.mismatches, ledger.pending());
      if (ledger.mismatches == 0 && ledger.pending() == 0) begin
         $display("ecg_beat_rate_classifier_tb passed");
      end else begin
         $display("ecg_beat_rate_classifier_tb failed");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl
rtl/ecgbrc_pkg.sv
rtl/ecgbrc_ctrl.sv
rtl/ecgbrc_dp.sv
rtl/ecg_beat_rate_classifier.sv
rtl/ecgbrc_checker.sv
tb/sv/ecg_beat_rate_classifier_tb.sv
